// ----- src/kde_pkg.sv -----
package kde_pkg;

  localparam int MAX_DIGITS = 3;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int DIDX_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int PCT_W      = 14;
  localparam int PERIOD_W   = 16;
  localparam int PROD_W     = 23;
  localparam int RECIP_W    = 24;
  localparam int RECIP_SH   = 30;
  localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
  localparam logic [6:0]  PCT_MAX  = 7'd100;

  localparam logic [7:0]  LOCKOUT_RST = 8'd1;
  localparam logic [15:0] PERIOD_RST  = 16'd2457;

  localparam logic CFG_LOCKOUT = 1'b0;
  localparam logic CFG_PERIOD  = 1'b1;

  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_EDGE = 1'b1;

  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_DIGIT = 2'd1,
    ECHO_PCT   = 2'd2,
    ECHO_CLAMP = 2'd3
  } echo_kind_t;

  typedef struct packed {
    logic       func;
    logic [1:0] row_index;
    logic       row_level_high;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  column_drive;
    logic        char_valid;
    logic [7:0]  echo_char;
    logic [15:0] compare_value;
    logic        last;
  } out_word_t;

  function automatic logic [7:0] key_at(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] k;
    k = 8'h00;
    unique case ({row, col})
      4'h0: k = 8'h31;
      4'h1: k = 8'h32;
      4'h2: k = 8'h33;
      4'h3: k = 8'h41;
      4'h4: k = 8'h34;
      4'h5: k = 8'h35;
      4'h6: k = 8'h36;
      4'h7: k = 8'h42;
      4'h8: k = 8'h37;
      4'h9: k = 8'h38;
      4'hA: k = 8'h39;
      4'hB: k = 8'h43;
      4'hC: k = 8'h2A;
      4'hD: k = 8'h30;
      4'hE: k = 8'h23;
      4'hF: k = 8'h44;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] word_count(input echo_kind_t kind);
    logic [2:0] n;
    n = 3'd1;
    case (kind)
      ECHO_PCT:   n = 3'd2;
      ECHO_CLAMP: n = 3'd6;
      default:    n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] echo_at(input echo_kind_t kind, input logic [2:0] idx,
                                         input logic [7:0] digit);
    logic [7:0] c;
    c = 8'h00;
    case (kind)
      ECHO_DIGIT: c = digit;
      ECHO_PCT:   c = (idx == 3'd0) ? CH_PCT : CH_LF;
      ECHO_CLAMP: begin
        case (idx)
          3'd0:    c = CH_CR;
          3'd1:    c = CH_1;
          3'd2:    c = CH_0;
          3'd3:    c = CH_0;
          3'd4:    c = CH_PCT;
          default: c = CH_LF;
        endcase
      end
      default:    c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- src/keypad_duty_entry.sv -----
// Channel | dir | handshake             | payload
// in      | in  | in_valid / in_ready   | in_word  (func, row_index, row_level_high)
// out     | out | out_valid / out_ready | out_word (column_drive .. last)
// cfg     | in  | cfg_we                | cfg_index, cfg_data
//
// Three stages: input register, key/state update with percent*period product,
// divide-by-100 (reciprocal multiply) into the output word register.
// An accepted input word passes the input, stage-1 and output word registers; an item
// that echoes nothing or one char gives one output word, a 'D' item two or six.
// One single-word item per cycle when out_ready holds.
// Reset is synchronous; all control and scan state clears, config takes defaults.
// out_ready low stalls the output register and backs up through to in_ready.
module keypad_duty_entry
  import kde_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  lockout_ticks_r;
  logic [15:0] period_r;

  logic [1:0]       col_r, col_nxt;
  logic [7:0]       lockout_r, lockout_nxt;
  logic [7:0]       key_r, key_nxt;
  logic [CNT_W-1:0] dcount_r, dcount_nxt;
  logic [3:0]       digits_r [MAX_DIGITS];
  logic [3:0]       digits_nxt [MAX_DIGITS];
  logic [3:0]       masks_r, masks_nxt;

  in_word_t in_r;
  logic     in_v_r;

  logic              s1_v_r;
  echo_kind_t        s1_kind_r, s1_kind_nxt;
  logic [7:0]        s1_char_r, s1_char_nxt;
  logic [PROD_W-1:0] s1_prod_r, s1_prod_nxt;
  logic [3:0]        s1_col_r;

  logic        s2_v_r;
  echo_kind_t  s2_kind_r;
  logic [7:0]  s2_char_r;
  logic [2:0]  s2_idx_r;
  logic [3:0]  s2_col_r;
  logic [15:0] compare_r;

  logic [7:0]  eff_lockout;
  logic        s2_last, en2, en1, adv0, in_acc;
  logic [PCT_W-1:0] pct_v;
  logic [6:0]  pct_c;
  logic [PROD_W+RECIP_W-1:0] quot_full;

  assign eff_lockout = (lockout_ticks_r == 8'd0) ? 8'd1 : lockout_ticks_r;
  assign s2_last     = (s2_idx_r == word_count(s2_kind_r) - 3'd1);
  assign en2         = !s2_v_r || (out_ready && s2_last);
  assign en1         = !s1_v_r || en2;
  assign in_ready    = !in_v_r || en1;
  assign in_acc      = in_valid && in_ready;
  assign adv0        = in_v_r && en1;

  always_comb begin
    pct_v = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (CNT_W'(i) < dcount_r) begin
        pct_v = PCT_W'(pct_v * 4'd10) + PCT_W'(digits_r[i]);
      end
    end
    pct_c = (pct_v > PCT_W'(PCT_MAX)) ? PCT_MAX : pct_v[6:0];
  end

  always_comb begin
    col_nxt     = col_r;
    lockout_nxt = lockout_r;
    key_nxt     = key_r;
    dcount_nxt  = dcount_r;
    digits_nxt  = digits_r;
    masks_nxt   = masks_r;
    s1_kind_nxt = ECHO_NONE;
    s1_char_nxt = key_r;
    s1_prod_nxt = PROD_W'(pct_c * period_r);
    if (in_r.func == FUNC_TICK) begin
      col_nxt = col_r + 2'd1;
      if (lockout_r != 8'd0 && lockout_r == eff_lockout) begin
        if (key_r >= CH_0 && key_r <= CH_9 && dcount_r < CNT_W'(MAX_DIGITS)) begin
          digits_nxt[dcount_r[DIDX_W-1:0]] = 4'(key_r - CH_0);
          dcount_nxt  = dcount_r + CNT_W'(1);
          s1_kind_nxt = ECHO_DIGIT;
        end
        if (key_r == CH_D) begin
          dcount_nxt = '0;
          for (int i = 0; i < MAX_DIGITS; i++) begin
            digits_nxt[i] = 4'd0;
          end
          s1_kind_nxt = (pct_v > PCT_W'(PCT_MAX)) ? ECHO_CLAMP : ECHO_PCT;
        end
      end
      if (lockout_r != 8'd0) begin
        lockout_nxt = lockout_r - 8'd1;
        if (lockout_r == 8'd1) begin
          masks_nxt = 4'd0;
        end
      end
    end else begin
      if (!masks_r[in_r.row_index] && in_r.row_level_high) begin
        masks_nxt[in_r.row_index] = 1'b1;
        key_nxt     = key_at(in_r.row_index, col_r);
        lockout_nxt = eff_lockout;
      end
    end
  end

  assign quot_full = s1_prod_r * RECIP_100;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_ticks_r <= LOCKOUT_RST;
      period_r        <= PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCKOUT: lockout_ticks_r <= cfg_data[7:0];
        CFG_PERIOD:  period_r        <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      lockout_r <= '0;
      key_r     <= '0;
      dcount_r  <= '0;
      masks_r   <= '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits_r[i] <= 4'd0;
      end
    end else if (adv0) begin
      col_r     <= col_nxt;
      lockout_r <= lockout_nxt;
      key_r     <= key_nxt;
      dcount_r  <= dcount_nxt;
      masks_r   <= masks_nxt;
      digits_r  <= digits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s2_idx_r  <= '0;
      compare_r <= '0;
      s1_kind_r <= ECHO_NONE;
      s2_kind_r <= ECHO_NONE;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (en1) begin
        s1_v_r <= in_v_r;
      end
      if (en2) begin
        s2_v_r   <= s1_v_r;
        s2_idx_r <= '0;
        if (s1_v_r) begin
          s2_kind_r <= s1_kind_r;
          if (s1_kind_r == ECHO_PCT || s1_kind_r == ECHO_CLAMP) begin
            compare_r <= quot_full[RECIP_SH +: 16];
          end
        end
      end else if (out_ready) begin
        s2_idx_r <= s2_idx_r + 3'd1;
      end
      if (adv0) begin
        s1_kind_r <= s1_kind_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_word;
    end
    if (adv0) begin
      s1_char_r <= s1_char_nxt;
      s1_prod_r <= s1_prod_nxt;
      s1_col_r  <= 4'(4'b0001 << col_nxt);
    end
    if (en2 && s1_v_r) begin
      s2_char_r <= s1_char_r;
      s2_col_r  <= s1_col_r;
    end
  end

  assign out_valid              = s2_v_r;
  assign out_word.column_drive  = s2_col_r;
  assign out_word.char_valid    = (s2_kind_r != ECHO_NONE);
  assign out_word.echo_char     = echo_at(s2_kind_r, s2_idx_r, s2_char_r);
  assign out_word.compare_value = compare_r;
  assign out_word.last          = s2_last;

`ifndef SYNTH
  a_masks_need_lockout: assert property (@(posedge clk) disable iff (!rst_n)
    (lockout_r == 8'd0) |-> (masks_r == 4'd0))
    else $error("row masks set with lockout expired");

  a_dcount_range: assert property (@(posedge clk) disable iff (!rst_n)
    dcount_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count overflow");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (s2_idx_r < word_count(s2_kind_r)))
    else $error("echo index past word count");

  a_d_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && (s1_kind_r == ECHO_PCT || s1_kind_r == ECHO_CLAMP)) |-> (dcount_r == '0))
    else $error("digits not cleared after D");

  a_col_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (adv0 && in_r.func == FUNC_TICK) |=> (col_r == $past(col_r) + 2'd1))
    else $error("column did not advance on tick");
`endif

endmodule
